FILE: src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the differential-drive odometry
// Fixed-point constants, CORDIC arctangent table, sequencer states and the
// result bundle passed from the CORDIC unit to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

    // CORDIC rotation count, capped at the table length
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_TAB    = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS > CORDIC_TAB) ? CORDIC_TAB : CORDIC_STEPS;
    localparam int CORDIC_CNT_W  = $clog2(CORDIC_ITERS);

    // Q30 constants
    localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
    localparam logic signed [31:0] HALFPI_Q30 = 32'sd1686629713;

    // half-turn scale round(2^48/(4000*pi)) = HI*2^32 + LO
    localparam logic signed [31:0] HALF_TURN_K_LO = 32'sd924230470;
    localparam int                 HALF_TURN_K_HI = 5;

    // ceil(2^39/1000): exact floor(m/1000) as (m*RECIP_1000)>>39 for m < 2^29
    localparam logic signed [31:0] RECIP_1000 = 32'sd549755814;

    // shared divider geometry
    localparam int DIV_W     = 40;
    localparam int DIVISOR_W = 11;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // configuration registers
    localparam logic [1:0] CFG_TRACK  = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [9:0] TRACK_RST  = 10'd142;
    localparam logic [9:0] PERIOD_RST = 10'd50;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL_P,
        ST_MUL_K,
        ST_REC_MUL,
        ST_REC_Q,
        ST_SUM_N,
        ST_DIV_H_GO,
        ST_DIV_H,
        ST_CORD_GO,
        ST_CORD,
        ST_FIX_Z,
        ST_FIX_Y,
        ST_FIX_X,
        ST_FIX_Q,
        ST_CH_LS,
        ST_CH_N,
        ST_CH_ABS,
        ST_DIV_C_GO,
        ST_DIV_C,
        ST_MOV_X,
        ST_MOV_Y,
        ST_UPD_X,
        ST_UPD_Y,
        ST_DONE
    } t_state;

    // CORDIC rotation result before the residual-angle correction
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  quad;
    } t_cord_res;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div: iterative unsigned divider
// Radix-2 restoring division, one quotient bit per cycle, DIV_W quotient bits.
// Quotient is held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ddo_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [ddo_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                               o_done,
    output logic [ddo_pkg::DIV_W-1:0]          o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [ddo_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [ddo_pkg::DIV_W-1:0]         r_q;
    logic [ddo_pkg::DIVISOR_W-1:0]     r_rem;
    logic [ddo_pkg::DIVISOR_W-1:0]     r_dsr;
    logic [ddo_pkg::DIVISOR_W:0]       trial;
    logic [ddo_pkg::DIVISOR_W:0]       diff;
    logic                              qbit;

    // trial subtract of the shifted remainder
    always_comb begin
        trial = {r_rem, r_q[ddo_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dsr};
        qbit  = (trial >= {1'b0, r_dsr});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[ddo_pkg::DIV_W-2:0], qbit};
            r_rem <= qbit ? diff[ddo_pkg::DIVISOR_W-1:0] : trial[ddo_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still iterating");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && !$past(i_start) |-> r_done)
        else $error("divider stopped without done");

endmodule

`default_nettype wire

FILE: src/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic: iterative CORDIC rotation unit
// Folds a 32-bit binary angle to the nearest quadrant, then runs one
// shift-add rotation per cycle. Returns x, y, residual angle and quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_angle,
    output logic                    o_done,
    output ddo_pkg::t_cord_res      o_res
);

    logic                               r_busy;
    logic                               r_done;
    logic [ddo_pkg::CORDIC_CNT_W-1:0]   r_cnt;
    logic signed [31:0]                 r_x;
    logic signed [31:0]                 r_y;
    logic signed [31:0]                 r_z;
    logic [1:0]                         r_quad;
    logic [31:0]                        biased;
    logic [31:0]                        folded;
    logic signed [31:0]                 xs;
    logic signed [31:0]                 ys;
    logic [31:0]                        atan_v;

    // quadrant fold and per-step shifts
    always_comb begin
        biased = i_angle + 32'h2000_0000;
        folded = i_angle - {biased[31:30], 30'b0};
        xs     = r_x >>> r_cnt;
        ys     = r_y >>> r_cnt;
        atan_v = ddo_pkg::atan_lut(5'(r_cnt));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ddo_pkg::CORDIC_CNT_W'(ddo_pkg::CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // rotations
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= ddo_pkg::GAIN_Q30;
            r_y    <= '0;
            r_z    <= $signed(folded);
            r_quad <= biased[31:30];
        end else if (r_busy) begin
            if (!r_z[31]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - $signed(atan_v);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + $signed(atan_v);
            end
        end
    end

    assign o_done     = r_done;
    assign o_res.x    = r_x;
    assign o_res.y    = r_y;
    assign o_res.z    = r_z;
    assign o_res.quad = r_quad;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("cordic restarted while busy");
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("cordic done without run");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("cordic done while rotating");

endmodule

`default_nettype wire

FILE: src/differential_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_top: two-pose dead-reckoning odometry
// One input transfer carries measured and commanded wheel speeds for one
// interval; one output transfer returns both updated poses.
//
// Channels: input i_in_valid/o_in_ready, output o_out_valid/i_out_ready,
// config i_cfg_valid/o_cfg_ready with i_cfg_index (0 track width, 1 period)
// and i_cfg_data. Config is always ready; write only while idle.
// A clear item goes straight to the done state and no pose is computed.
// Each pose on equal wheel speeds takes one CORDIC run and no divider pass;
// on unequal speeds it takes two passes of the radix-2 divider and two
// CORDIC runs; two poses per item. The divider and the CORDIC unit are both
// shared by the poses under one sequencer with one 32x32 multiplier.
// Throughput: one item at a time; o_in_ready is high only when idle.
// The result sits in an output register, so the next item is taken while a
// result waits; a finished item then holds until that register frees up.
// Reset: poses clear to zero, track width 142 mm, period 50 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [9:0]         i_cfg_data,
    // input item
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_clear_pose,
    input  wire logic signed [10:0] i_meas_left_speed,
    input  wire logic signed [10:0] i_meas_right_speed,
    input  wire logic signed [10:0] i_cmd_left_speed,
    input  wire logic signed [10:0] i_cmd_right_speed,
    // result item
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_meas_pos_x,
    output logic signed [31:0]      o_meas_pos_y,
    output logic [15:0]             o_meas_heading,
    output logic signed [31:0]      o_cmd_pos_x,
    output logic signed [31:0]      o_cmd_pos_y,
    output logic [15:0]             o_cmd_heading,
    output logic                    o_moving_straight
);

    function automatic logic [31:0] sat32(input logic [34:0] v);
        logic [31:0] r;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // control state
    ddo_pkg::t_state    r_state, n_state;
    logic               r_pose;
    logic               r_ret;
    logic               r_out_valid;
    logic [9:0]         r_track;
    logic [9:0]         r_period;

    // poses
    logic signed [31:0] r_px [2];
    logic signed [31:0] r_py [2];
    logic [15:0]        r_pa [2];

    // latched item
    logic               r_in_clear;
    logic signed [10:0] r_in_ml, r_in_mr, r_in_cl, r_in_cr;

    // working registers
    logic signed [11:0] r_dv, r_sum;
    logic               r_straight;
    logic [9:0]         r_len, r_per;
    logic signed [63:0] r_prod;
    logic [20:0]        r_p1;
    logic [55:0]        r_acc;
    logic [31:0]        r_hu;
    logic [15:0]        r_dth;
    logic [31:0]        r_cang;
    logic               r_cneg;
    logic signed [31:0] r_c, r_zr, r_t, r_co, r_si;
    logic signed [33:0] r_d;

    // output register
    logic signed [31:0] r_o_mx, r_o_my, r_o_cx, r_o_cy;
    logic [15:0]        r_o_mh, r_o_ch;
    logic               r_o_straight;

    // shared units
    logic                           div_start, div_done;
    logic [ddo_pkg::DIV_W-1:0]      div_dividend, div_quot;
    logic [ddo_pkg::DIVISOR_W-1:0]  div_divisor;
    logic                           cord_start, cord_done;
    ddo_pkg::t_cord_res             cord_res;
    logic signed [31:0]             mul_a, mul_b;

    // combinational helpers
    logic               in_xfer;
    logic signed [10:0] sel_l, sel_r;
    logic [11:0]        neg_dv, abs_sum;
    logic [10:0]        abs_dv;
    logic [56:0]        h_num, c_num;
    logic [23:0]        p1x5;
    logic [63:0]        prod_abs;
    logic [63:0]        prod_rnd;
    logic [31:0]        q32;
    logic [31:0]        rec_q;
    logic [40:0]        dth_full;
    logic [15:0]        dth_mag;
    logic signed [31:0] cx, cy, res_y, corr;
    logic [34:0]        x_sum, y_sum;

    assign in_xfer = i_in_valid && o_in_ready;

    always_comb begin
        sel_l    = r_pose ? r_in_cl : r_in_ml;
        sel_r    = r_pose ? r_in_cr : r_in_mr;
        neg_dv   = 12'(-r_dv);
        abs_dv   = r_dv[11] ? neg_dv[10:0] : r_dv[10:0];
        abs_sum  = r_sum[11] ? 12'(~r_sum + 12'd1) : r_sum;
        h_num    = {1'b0, r_acc} + {32'b0, r_len, 15'b0};
        c_num    = {1'b0, r_acc} + {25'b0, abs_dv, 21'b0};
        p1x5     = {1'b0, r_p1, 2'b00} + {3'b000, r_p1};
        prod_abs = r_prod[63] ? 64'(-r_prod) : r_prod;
        prod_rnd = r_prod + 64'sd536870912;
        q32      = div_quot[31:0];
        rec_q    = {7'b0, r_prod[63:39]};
        dth_full = {1'b0, div_quot} + 41'd16384;
        dth_mag  = dth_full[30:15];
        cx       = $signed(cord_res.x);
        cy       = $signed(cord_res.y);
        corr     = r_prod[61:30];
        res_y    = cy + corr;
        x_sum    = {{3{r_px[r_pose][31]}}, r_px[r_pose]} + {r_d[33], r_d};
        y_sum    = {{3{r_py[r_pose][31]}}, r_py[r_pose]} + {r_d[33], r_d};
    end

    // sequencer: next state, unit starts and multiplier operands
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        cord_start   = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_dividend = h_num[55:16];
        div_divisor  = {1'b0, r_len};
        case (r_state)
            ddo_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_clear_pose ? ddo_pkg::ST_DONE : ddo_pkg::ST_SETUP;
                end
            end
            ddo_pkg::ST_SETUP: n_state = ddo_pkg::ST_MUL_P;
            ddo_pkg::ST_MUL_P: begin
                mul_a   = r_straight ? {20'b0, abs_sum} : {21'b0, abs_dv};
                mul_b   = {22'b0, r_per};
                n_state = ddo_pkg::ST_MUL_K;
            end
            ddo_pkg::ST_MUL_K: begin
                if (r_straight) begin
                    n_state = ddo_pkg::ST_REC_MUL;
                end else begin
                    mul_a   = r_prod[31:0];
                    mul_b   = ddo_pkg::HALF_TURN_K_LO;
                    n_state = ddo_pkg::ST_SUM_N;
                end
            end
            // straight chord: divide by 1000 through the reciprocal
            ddo_pkg::ST_REC_MUL: begin
                mul_a   = r_acc[31:0];
                mul_b   = ddo_pkg::RECIP_1000;
                n_state = ddo_pkg::ST_REC_Q;
            end
            ddo_pkg::ST_REC_Q: n_state = ddo_pkg::ST_CORD_GO;
            ddo_pkg::ST_SUM_N: n_state = ddo_pkg::ST_DIV_H_GO;
            ddo_pkg::ST_DIV_H_GO: begin
                div_start = 1'b1;
                n_state   = ddo_pkg::ST_DIV_H;
            end
            ddo_pkg::ST_DIV_H: begin
                if (div_done) begin
                    n_state = ddo_pkg::ST_CORD_GO;
                end
            end
            ddo_pkg::ST_CORD_GO: begin
                cord_start = 1'b1;
                n_state    = ddo_pkg::ST_CORD;
            end
            ddo_pkg::ST_CORD: begin
                if (cord_done) begin
                    n_state = ddo_pkg::ST_FIX_Z;
                end
            end
            ddo_pkg::ST_FIX_Z: begin
                mul_a   = $signed(cord_res.z);
                mul_b   = ddo_pkg::HALFPI_Q30;
                n_state = ddo_pkg::ST_FIX_Y;
            end
            ddo_pkg::ST_FIX_Y: begin
                mul_a   = cy;
                mul_b   = corr;
                n_state = ddo_pkg::ST_FIX_X;
            end
            ddo_pkg::ST_FIX_X: begin
                mul_a   = cx;
                mul_b   = r_zr;
                n_state = ddo_pkg::ST_FIX_Q;
            end
            ddo_pkg::ST_FIX_Q: n_state = r_ret ? ddo_pkg::ST_MOV_X : ddo_pkg::ST_CH_LS;
            ddo_pkg::ST_CH_LS: begin
                mul_a   = {22'b0, r_len};
                mul_b   = {{20{r_sum[11]}}, r_sum};
                n_state = ddo_pkg::ST_CH_N;
            end
            ddo_pkg::ST_CH_N: begin
                mul_a   = r_prod[31:0];
                mul_b   = r_si;
                n_state = ddo_pkg::ST_CH_ABS;
            end
            ddo_pkg::ST_CH_ABS: n_state = ddo_pkg::ST_DIV_C_GO;
            ddo_pkg::ST_DIV_C_GO: begin
                div_start    = 1'b1;
                div_dividend = {5'b0, c_num[56:22]};
                div_divisor  = abs_dv;
                n_state      = ddo_pkg::ST_DIV_C;
            end
            ddo_pkg::ST_DIV_C: begin
                if (div_done) begin
                    n_state = ddo_pkg::ST_CORD_GO;
                end
            end
            ddo_pkg::ST_MOV_X: begin
                mul_a   = r_c;
                mul_b   = r_co;
                n_state = ddo_pkg::ST_MOV_Y;
            end
            ddo_pkg::ST_MOV_Y: begin
                mul_a   = r_c;
                mul_b   = r_si;
                n_state = ddo_pkg::ST_UPD_X;
            end
            ddo_pkg::ST_UPD_X: n_state = ddo_pkg::ST_UPD_Y;
            ddo_pkg::ST_UPD_Y: n_state = r_pose ? ddo_pkg::ST_DONE : ddo_pkg::ST_SETUP;
            ddo_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ddo_pkg::ST_IDLE;
                end
            end
            default: n_state = ddo_pkg::ST_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
            r_pose  <= 1'b0;
            r_ret   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_pose <= 1'b0;
            end else if (r_state == ddo_pkg::ST_UPD_Y) begin
                r_pose <= 1'b1;
            end
            if (r_state == ddo_pkg::ST_DIV_H && div_done) begin
                r_ret <= 1'b0;
            end else if (r_state == ddo_pkg::ST_DIV_C && div_done) begin
                r_ret <= 1'b1;
            end else if (r_state == ddo_pkg::ST_REC_Q) begin
                r_ret <= 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track  <= ddo_pkg::TRACK_RST;
            r_period <= ddo_pkg::PERIOD_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ddo_pkg::CFG_TRACK) begin
                r_track <= i_cfg_data;
            end else if (i_cfg_index == ddo_pkg::CFG_PERIOD) begin
                r_period <= i_cfg_data;
            end
        end
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_px[i] <= '0;
                r_py[i] <= '0;
                r_pa[i] <= '0;
            end
        end else if (in_xfer && i_clear_pose) begin
            for (int i = 0; i < 2; i++) begin
                r_px[i] <= '0;
                r_py[i] <= '0;
                r_pa[i] <= '0;
            end
        end else if (r_state == ddo_pkg::ST_UPD_X) begin
            r_px[r_pose] <= sat32(x_sum);
        end else if (r_state == ddo_pkg::ST_UPD_Y) begin
            r_py[r_pose] <= sat32(y_sum);
            r_pa[r_pose] <= r_pa[r_pose] + r_dth;
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ddo_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_in_clear <= i_clear_pose;
                    r_in_ml    <= i_meas_left_speed;
                    r_in_mr    <= i_meas_right_speed;
                    r_in_cl    <= i_cmd_left_speed;
                    r_in_cr    <= i_cmd_right_speed;
                end
            end
            ddo_pkg::ST_SETUP: begin
                r_dv       <= {sel_r[10], sel_r} - {sel_l[10], sel_l};
                r_sum      <= {sel_r[10], sel_r} + {sel_l[10], sel_l};
                r_straight <= (sel_l == sel_r);
                r_len      <= (r_track == 10'd0) ? 10'd1 : r_track;
                r_per      <= r_period;
                r_hu       <= '0;
                r_dth      <= '0;
            end
            ddo_pkg::ST_MUL_K: begin
                if (r_straight) begin
                    r_acc  <= {28'b0, r_prod[20:0], 7'b0} + 56'd500;
                    r_cneg <= r_sum[11];
                end else begin
                    r_p1   <= r_prod[20:0];
                end
            end
            ddo_pkg::ST_REC_Q: begin
                r_c    <= r_cneg ? $signed(32'(-rec_q)) : $signed(rec_q);
                r_cang <= {r_pa[r_pose], 16'b0} + r_hu;
            end
            ddo_pkg::ST_SUM_N: r_acc <= r_prod[55:0] + {p1x5, 32'b0};
            ddo_pkg::ST_DIV_H: begin
                if (div_done) begin
                    r_hu   <= r_dv[11] ? 32'(-q32) : q32;
                    r_dth  <= r_dv[11] ? 16'(-dth_mag) : dth_mag;
                    r_cang <= r_dv[11] ? 32'(-q32) : q32;
                end
            end
            ddo_pkg::ST_FIX_Y: r_zr <= corr;
            ddo_pkg::ST_FIX_X: r_t  <= cx - corr;
            ddo_pkg::ST_FIX_Q: begin
                case (cord_res.quad)
                    2'd0: begin
                        r_co <= r_t;
                        r_si <= res_y;
                    end
                    2'd1: begin
                        r_co <= -res_y;
                        r_si <= r_t;
                    end
                    2'd2: begin
                        r_co <= -r_t;
                        r_si <= -res_y;
                    end
                    default: begin
                        r_co <= res_y;
                        r_si <= -r_t;
                    end
                endcase
            end
            ddo_pkg::ST_CH_ABS: begin
                r_acc  <= prod_abs[55:0];
                r_cneg <= r_prod[63] ^ r_dv[11];
            end
            ddo_pkg::ST_DIV_C: begin
                if (div_done) begin
                    r_c    <= r_cneg ? $signed(32'(-q32)) : $signed(q32);
                    r_cang <= {r_pa[r_pose], 16'b0} + r_hu;
                end
            end
            ddo_pkg::ST_MOV_Y: r_d <= prod_rnd[63:30];
            ddo_pkg::ST_UPD_X: r_d <= prod_rnd[63:30];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ddo_pkg::ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddo_pkg::ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_o_mx       <= r_px[0];
            r_o_my       <= r_py[0];
            r_o_mh       <= r_pa[0];
            r_o_cx       <= r_px[1];
            r_o_cy       <= r_py[1];
            r_o_ch       <= r_pa[1];
            r_o_straight <= (r_in_ml == r_in_mr);
        end
    end

    ddo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (r_cang),
        .o_done  (cord_done),
        .o_res   (cord_res)
    );

    assign o_cfg_ready       = 1'b1;
    assign o_in_ready        = (r_state == ddo_pkg::ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_meas_pos_x      = r_o_mx;
    assign o_meas_pos_y      = r_o_my;
    assign o_meas_heading    = r_o_mh;
    assign o_cmd_pos_x       = r_o_cx;
    assign o_cmd_pos_y       = r_o_cy;
    assign o_cmd_heading     = r_o_ch;
    assign o_moving_straight = r_o_straight;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("input taken while item in progress");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_clear_pose |=> r_px[0] == 0 && r_py[1] == 0 && r_pa[0] == 0)
        else $error("clear did not zero poses");
    a_cord_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> r_state == ddo_pkg::ST_CORD)
        else $error("cordic result outside wait state");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ddo_pkg::ST_DIV_H || r_state == ddo_pkg::ST_DIV_C))
        else $error("divider result outside wait state");
    a_clear_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ddo_pkg::ST_SETUP |-> !r_in_clear)
        else $error("pose update started on a clear item");

endmodule

`default_nettype wire

FILE: tb/sv/differential_drive_odometry_top_tb.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_top_tb: self-checking bench for the odometry
// Drives wheel-speed transfers through the valid/ready channels, predicts
// both poses with a bit-exact fixed-point model of the arc kinematics, and
// checks every returned pose transfer field by field. Runs several track and
// period settings (zero and full-scale among them), random idling on both
// sides, and a straight run at full speed and full period.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top_tb;

    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     RUN_ITEMS      = 100;
    localparam longint HALF_TURN_SCALE = 64'sd22399066950;
    localparam longint CORDIC_GAIN     = 64'sd652032874;
    localparam longint QUARTER_RAD     = 64'sd1686629713;

    // arctangent of 2^-i, 2^-32 turn units
    localparam longint ATAN_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct {
        logic               clear;
        logic signed [10:0] meas_l;
        logic signed [10:0] meas_r;
        logic signed [10:0] cmd_l;
        logic signed [10:0] cmd_r;
    } speed_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        heading;
    } pose_t;

    typedef struct {
        pose_t meas;
        pose_t cmd;
        logic  straight;
    } pose_pair_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [9:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_clear_pose;
    logic signed [10:0] i_meas_left_speed;
    logic signed [10:0] i_meas_right_speed;
    logic signed [10:0] i_cmd_left_speed;
    logic signed [10:0] i_cmd_right_speed;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_meas_pos_x;
    logic signed [31:0] o_meas_pos_y;
    logic [15:0]        o_meas_heading;
    logic signed [31:0] o_cmd_pos_x;
    logic signed [31:0] o_cmd_pos_y;
    logic [15:0]        o_cmd_heading;
    logic               o_moving_straight;

    differential_drive_odometry_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_clear_pose       (i_clear_pose),
        .i_meas_left_speed  (i_meas_left_speed),
        .i_meas_right_speed (i_meas_right_speed),
        .i_cmd_left_speed   (i_cmd_left_speed),
        .i_cmd_right_speed  (i_cmd_right_speed),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_meas_pos_x       (o_meas_pos_x),
        .o_meas_pos_y       (o_meas_pos_y),
        .o_meas_heading     (o_meas_heading),
        .o_cmd_pos_x        (o_cmd_pos_x),
        .o_cmd_pos_y        (o_cmd_pos_y),
        .o_cmd_heading      (o_cmd_heading),
        .o_moving_straight  (o_moving_straight)
    );

    // bench state
    speed_item_t speed_item_q[$];
    pose_pair_t  pose_expect_q[$];
    speed_item_t cur_item;
    pose_t       meas_pose;
    pose_t       cmd_pose;
    logic [9:0]  track_mm;
    logic [9:0]  period_ms;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        send_hold;
    int          n_items;
    int          n_results;
    int          n_cfg;
    int          n_errors;
    int          quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // pose predictor
    // ------------------------------------------------------------------
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // quadrant fold, CORDIC rotations, then a first-order residual fix
    function automatic void sin_cos(input logic [31:0] ang,
                                    output longint cos_q30, output longint sin_q30);
        logic [31:0] sum_q;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint      x, y, z, xs, ys, zr, t;
        sum_q = ang + 32'h2000_0000;
        quad  = sum_q[31:30];
        resid = ang - {quad, 30'b0};
        z = $signed(resid);
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < ddo_pkg::CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
            end
        end
        zr = (z * QUARTER_RAD) >>> 30;
        t  = x - ((y * zr) >>> 30);
        y  = y + ((x * zr) >>> 30);
        x  = t;
        case (quad)
            2'd0: begin cos_q30 = x;  sin_q30 = y;  end
            2'd1: begin cos_q30 = -y; sin_q30 = x;  end
            2'd2: begin cos_q30 = -x; sin_q30 = -y; end
            default: begin cos_q30 = y; sin_q30 = -x; end
        endcase
    endfunction

    // exact-arc move of one pose for one interval
    function automatic pose_t arc_step(input pose_t p, input int vl, input int vr);
        longint      dv, sum, trk, per, half, chord, co, si, num, den, dturn;
        logic [31:0] half_u, dir;
        pose_t       r;
        dv   = vr - vl;
        sum  = vr + vl;
        trk  = (track_mm == 0) ? 1 : longint'(track_mm);
        per  = longint'(period_ms);
        half = 0;
        if (dv != 0) half = round_div(dv * per * HALF_TURN_SCALE, trk * 65536);
        half_u = half[31:0];
        if (dv == 0) begin
            chord = round_div(sum * per * 128, 1000);
        end else begin
            sin_cos(half_u, co, si);
            num = trk * sum * si;
            den = dv * 4194304;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            chord = round_div(num, den);
        end
        dir = {p.heading, 16'b0} + half_u;
        sin_cos(dir, co, si);
        r.x = clamp32(longint'(p.x) + ((chord * co + (64'sd1 <<< 29)) >>> 30));
        r.y = clamp32(longint'(p.y) + ((chord * si + (64'sd1 <<< 29)) >>> 30));
        dturn = round_div(half, 32768);
        r.heading = p.heading + dturn[15:0];
        return r;
    endfunction

    // advance both poses for one accepted transfer, return the expected result
    function automatic pose_pair_t predict_poses(input speed_item_t it);
        pose_pair_t e;
        if (it.clear) begin
            meas_pose = '{0, 0, 0};
            cmd_pose  = '{0, 0, 0};
        end else begin
            meas_pose = arc_step(meas_pose, it.meas_l, it.meas_r);
            cmd_pose  = arc_step(cmd_pose, it.cmd_l, it.cmd_r);
        end
        e.meas     = meas_pose;
        e.cmd      = cmd_pose;
        e.straight = (it.meas_l == it.meas_r);
        return e;
    endfunction

    // ------------------------------------------------------------------
    // mismatch report
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input longint got, input longint want);
        n_errors++;
        if (n_errors <= 40)
            $display("MISMATCH result %0d %s: got %0d expected %0d",
                     n_results, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // input driver: one transfer in flight, fed from the pending queue
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pose_expect_q.push_back(predict_poses(cur_item));
                n_items++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (speed_item_q.size() > 0 && !send_hold &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item            = speed_item_q.pop_front();
                    i_in_valid         <= 1'b1;
                    i_clear_pose       <= cur_item.clear;
                    i_meas_left_speed  <= cur_item.meas_l;
                    i_meas_right_speed <= cur_item.meas_r;
                    i_cmd_left_speed   <= cur_item.cmd_l;
                    i_cmd_right_speed  <= cur_item.cmd_r;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        pose_pair_t e;
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pose_expect_q.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                e = pose_expect_q.pop_front();
                if (o_meas_pos_x !== e.meas.x)
                    report_mismatch("meas_pos_x", o_meas_pos_x, e.meas.x);
                if (o_meas_pos_y !== e.meas.y)
                    report_mismatch("meas_pos_y", o_meas_pos_y, e.meas.y);
                if (o_meas_heading !== e.meas.heading)
                    report_mismatch("meas_heading", o_meas_heading, e.meas.heading);
                if (o_cmd_pos_x !== e.cmd.x)
                    report_mismatch("cmd_pos_x", o_cmd_pos_x, e.cmd.x);
                if (o_cmd_pos_y !== e.cmd.y)
                    report_mismatch("cmd_pos_y", o_cmd_pos_y, e.cmd.y);
                if (o_cmd_heading !== e.cmd.heading)
                    report_mismatch("cmd_heading", o_cmd_heading, e.cmd.heading);
                if (o_moving_straight !== e.straight)
                    report_mismatch("moving_straight", o_moving_straight, e.straight);
            end
            n_results++;
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** differential_drive_odometry_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [10:0] rand_speed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)  return -11'sd1024;
        if (pick < 8)  return 11'sd1023;
        if (pick < 11) return 11'sd0;
        if (pick < 20) return 11'($urandom_range(0, 200)) - 11'sd100;
        return 11'($urandom_range(0, 2047));
    endfunction

    function automatic speed_item_t make_item(input logic clr, input int ml, input int mr,
                                              input int cl, input int cr);
        speed_item_t it;
        it.clear  = clr;
        it.meas_l = ml[10:0];
        it.meas_r = mr[10:0];
        it.cmd_l  = cl[10:0];
        it.cmd_r  = cr[10:0];
        return it;
    endfunction

    // mostly motion with random content, some straight runs, rare clears
    function automatic speed_item_t rand_item();
        speed_item_t it;
        int          pick;
        it.clear  = ($urandom_range(0, 99) < 3);
        it.meas_l = rand_speed();
        it.meas_r = rand_speed();
        it.cmd_l  = rand_speed();
        it.cmd_r  = rand_speed();
        pick = $urandom_range(0, 99);
        if (pick < 20) it.meas_r = it.meas_l;
        else if (pick < 25) it.meas_r = it.meas_l + 11'sd1;
        if ($urandom_range(0, 99) < 20) it.cmd_r = it.cmd_l;
        return it;
    endfunction

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (speed_item_q.size() > 0 || pose_expect_q.size() > 0 || i_in_valid);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == ddo_pkg::CFG_TRACK) track_mm = val;
        else period_ms = val;
        n_cfg++;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    logic [9:0] phase_track [8] = '{10'd142, 10'd0,    10'd1,   10'd1023,
                                    10'd1023, 10'd57,  10'd300, 10'd0};
    logic [9:0] phase_period[8] = '{10'd50,  10'd0,    10'd1023, 10'd1,
                                    10'd1023, 10'd1000, 10'd20,  10'd333};

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = ddo_pkg::CFG_TRACK;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_out_ready        = 1'b0;
        i_clear_pose       = 1'b0;
        i_meas_left_speed  = '0;
        i_meas_right_speed = '0;
        i_cmd_left_speed   = '0;
        i_cmd_right_speed  = '0;
        track_mm           = ddo_pkg::TRACK_RST;
        period_ms          = ddo_pkg::PERIOD_RST;
        meas_pose          = '{0, 0, 0};
        cmd_pose           = '{0, 0, 0};
        send_hold          = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        n_items = 0; n_results = 0; n_cfg = 0; n_errors = 0; quiet_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extremes, straight, spin, clear
        speed_item_q.push_back(make_item(0, 0, 0, 0, 0));
        speed_item_q.push_back(make_item(0, 1023, 1023, -1024, -1024));
        speed_item_q.push_back(make_item(0, -1024, 1023, 1023, -1024));
        speed_item_q.push_back(make_item(0, 1023, -1024, -1024, 1023));
        speed_item_q.push_back(make_item(0, 100, 101, 500, 500));
        speed_item_q.push_back(make_item(0, -1, 0, 0, -1));
        speed_item_q.push_back(make_item(1, 300, 300, 7, -9));
        speed_item_q.push_back(make_item(0, 200, 400, 400, 200));
        speed_item_q.push_back(make_item(1, 5, -5, 0, 0));
        speed_item_q.push_back(make_item(0, -1024, -1024, 1023, 1023));
        speed_item_q.push_back(make_item(0, -1024, -1023, 1022, 1023));
        speed_item_q.push_back(make_item(0, 1023, 1023, 1023, 1023));
        speed_item_q.push_back(make_item(0, -700, 700, 0, 1023));
        speed_item_q.push_back(make_item(0, 1023, 0, -1024, 0));
        for (int i = 0; i < 8; i++)
            speed_item_q.push_back(make_item(0, 0, 1023, 0, -1024));
        wait_drained();

        // random phases across track and period settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(ddo_pkg::CFG_TRACK, phase_track[ph]);
            write_reg(ddo_pkg::CFG_PERIOD, phase_period[ph]);
            set_idling(ph);
            speed_item_q.push_back(make_item(1, 0, 0, 0, 0));
            for (int i = 0; i < 125; i++) speed_item_q.push_back(rand_item());
            if (ph == 3) begin
                // once the block has drained, the sender holds off before the next items
                wait_drained();
                send_hold <= 1'b1;
                repeat (20) @(posedge i_clk);
                send_hold <= 1'b0;
            end
            for (int i = 0; i < 125; i++) speed_item_q.push_back(rand_item());
            wait_drained();
        end

        // straight run at full speed and full period
        write_reg(ddo_pkg::CFG_TRACK, 10'd142);
        write_reg(ddo_pkg::CFG_PERIOD, 10'd1023);
        set_idling(0);
        speed_item_q.push_back(make_item(1, 0, 0, 0, 0));
        for (int i = 0; i < RUN_ITEMS; i++)
            speed_item_q.push_back(make_item(0, 1023, 1023, -1024, -1024));
        for (int i = 0; i < 40; i++) speed_item_q.push_back(rand_item());
        wait_drained();

        repeat (400) @(posedge i_clk);
        $display("run: %0d speed transfers, %0d pose results, %0d register writes",
                 n_items, n_results, n_cfg);
        $display("covered 9 track/period settings, idling mixes, clears, full-speed run");
        if (n_errors == 0 && pose_expect_q.size() == 0)
            $display("** differential_drive_odometry_top: PASSED **");
        else
            $display("** differential_drive_odometry_top: FAILED **");
        $finish;
    end

endmodule
